>>> rtl/esc_pkg.sv
// Shared types and constants for the epoch seconds to calendar core.
// Used by esc_front, esc_back and the top level.
`default_nettype none

package esc_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_TZ_OFFSET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAYLIGHT  = 1'b1;

    localparam int SECS_PER_MIN  = 60;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_DAY  = 86400;
    localparam int SEC_W         = 17;
    localparam int EPOCH_YEAR_OFS = 70;

    localparam logic [3:0] MONTH_JAN = 4'd0;
    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [3:0] MONTH_MAR = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd3;
    localparam logic [3:0] MONTH_MAY = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd5;
    localparam logic [3:0] MONTH_JUL = 4'd6;
    localparam logic [3:0] MONTH_AUG = 4'd7;
    localparam logic [3:0] MONTH_SEP = 4'd8;
    localparam logic [3:0] MONTH_OCT = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd10;
    localparam logic [3:0] MONTH_DEC = 4'd11;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_WALK,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        logic daylight;
        logic clamped;
    } t_job_flags;

    typedef struct packed {
        logic [5:0] second_of_minute;
        logic [5:0] minute_of_hour;
        logic [4:0] hour_of_day;
        logic [2:0] weekday;
        logic [8:0] day_of_year;
        logic [3:0] month_index;
        logic [4:0] day_of_month;
        logic [7:0] years_since_1900;
        logic       daylight_flag;
        logic       clamped;
    } t_result;

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

>>> rtl/esc_front.sv
// Front stage: configuration registers, timezone and daylight adjustment, clamping.
// Depends on esc_pkg; feeds esc_queue with a packed job word.
`default_nettype none

module esc_front #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [esc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [esc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [31:0]                     i_epoch_seconds,
    output logic                                 o_push,
    input  wire logic                            i_push_ready,
    output logic [TIME_BITS+2:0]                 o_job
);
    import esc_pkg::*;

    localparam int TW = TIME_BITS + 1;
    localparam int AW = TIME_BITS + 2;

    logic signed [CFG_DATA_W-1:0] r_tz;
    logic                         r_dst;
    logic                         r_valid;
    logic [TW-1:0]                r_time;
    t_job_flags                   r_flags;
    logic signed [AW-1:0]         w_adj;
    logic                         w_take;

    assign w_adj = $signed(AW'(i_epoch_seconds)) - AW'(r_tz)
                 + (r_dst ? AW'(SECS_PER_HOUR) : AW'(0));
    assign o_ready = !r_valid || i_push_ready;
    assign w_take  = i_valid && o_ready;
    assign o_push  = r_valid;
    assign o_job   = {r_flags, r_time};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tz    <= '0;
            r_dst   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TZ_OFFSET: r_tz <= $signed(i_cfg_data);
                    CFG_DAYLIGHT:  r_dst <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_take) begin
                r_valid <= 1'b1;
            end else if (i_push_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_flags.daylight <= r_dst;
            r_flags.clamped  <= w_adj[AW-1];
            r_time           <= w_adj[AW-1] ? '0 : w_adj[TW-1:0];
        end
    end

endmodule

`default_nettype wire

>>> rtl/esc_queue.sv
// Two-entry job queue between the front and back stages.
// No package dependencies beyond the width parameter.
`default_nettype none

module esc_queue #(
    parameter int WIDTH = 35
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    input  wire logic             i_pop
);
    logic [WIDTH-1:0] r_slot [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_rptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

    a_pop_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push && r_count != 2'd0) |=> (r_count == $past(r_count) - 2'd1))
        else $error("queue count did not drop after pop");

endmodule

`default_nettype wire

>>> rtl/esc_back.sv
// Back stage: day split by reciprocal multiplication, then parallel year/month walk and
// time-of-day walk. Depends on esc_pkg; takes jobs from esc_queue and holds one result register.
`default_nettype none

module esc_back #(
    parameter int TIME_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire logic [TIME_BITS+2:0] i_q_data,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output esc_pkg::t_result        o_result
);
    import esc_pkg::*;

    localparam int TW            = TIME_BITS + 1;
    localparam int DW            = TW - 16;
    localparam int YW            = DW - 8;
    localparam int CW            = 1;
    localparam int DAY_SHIFT     = 7;
    localparam int DAY_ODD       = SECS_PER_DAY >> DAY_SHIFT;
    localparam int XW            = TW - DAY_SHIFT;
    localparam int KD            = XW + $clog2(DAY_ODD);
    localparam int DAYS_PER_WEEK = 7;
    localparam int K7            = DW + $clog2(DAYS_PER_WEEK);
    localparam logic [XW:0] DAY_RECIP =
        (XW+1)'(((64'd1 << KD) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));
    localparam logic [DW:0] WEEK_RECIP =
        (DW+1)'(((64'd1 << K7) + 64'(DAYS_PER_WEEK) - 64'd1) / 64'(DAYS_PER_WEEK));

    t_back_state      r_state, n_state;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;
    logic [TW-1:0]    r_quot, n_quot;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [2:0]       r_wd, n_wd;
    t_job_flags       r_flags, n_flags;
    logic [DW-1:0]    r_days, n_days;
    logic [SEC_W-1:0] r_sec, n_sec;
    logic [4:0]       r_hour, n_hour;
    logic [5:0]       r_min, n_min;
    logic [YW-1:0]    r_yoff, n_yoff;
    logic [1:0]       r_m4, n_m4;
    logic [6:0]       r_m100, n_m100;
    logic [8:0]       r_m400, n_m400;
    logic [3:0]       r_mon, n_mon;
    logic [8:0]       r_doy, n_doy;
    logic             r_mon_phase, n_mon_phase;
    logic             r_cal_done, n_cal_done;
    logic             r_min_phase, n_min_phase;
    logic             r_tod_done, n_tod_done;

    logic             w_leap;
    logic [8:0]       w_year_len;
    logic [4:0]       w_mon_len;
    logic [2*XW:0]    w_day_prod;
    logic [DW-1:0]    w_days_q;
    logic [SEC_W-1:0] w_day_secs;
    logic [SEC_W-1:0] w_sec_rem;
    logic [2*DW:0]    w_week_prod;
    logic [DW-3:0]    w_week_q;
    logic [2:0]       w_wd;
    logic [3:0]       w_wd4;
    logic [YW-1:0]    w_year;

    assign w_leap      = (r_m4 == 2'd0) && ((r_m100 != 7'd0) || (r_m400 == 9'd0));
    assign w_year_len  = w_leap ? 9'd366 : 9'd365;
    assign w_mon_len   = month_len(r_mon, w_leap);
    assign w_day_prod  = (2*XW+1)'(r_quot[TW-1:DAY_SHIFT]) * (2*XW+1)'(DAY_RECIP);
    assign w_days_q    = w_day_prod[2*XW:KD];
    assign w_day_secs  = SEC_W'(r_days * DW'(SECS_PER_DAY));
    assign w_sec_rem   = r_quot[SEC_W-1:0] - w_day_secs;
    assign w_week_prod = (2*DW+1)'(r_days) * (2*DW+1)'(WEEK_RECIP);
    assign w_week_q    = w_week_prod[2*DW:K7];
    assign w_wd        = 3'(r_days - DW'(w_week_q) * DW'(DAYS_PER_WEEK));
    assign w_wd4       = {1'b0, r_wd} + 4'd4;
    assign w_year      = r_yoff + YW'(EPOCH_YEAR_OFS);
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        n_quot      = r_quot;
        n_cnt       = r_cnt;
        n_wd        = r_wd;
        n_flags     = r_flags;
        n_days      = r_days;
        n_sec       = r_sec;
        n_hour      = r_hour;
        n_min       = r_min;
        n_yoff      = r_yoff;
        n_m4        = r_m4;
        n_m100      = r_m100;
        n_m400      = r_m400;
        n_mon       = r_mon;
        n_doy       = r_doy;
        n_mon_phase = r_mon_phase;
        n_cal_done  = r_cal_done;
        n_min_phase = r_min_phase;
        n_tod_done  = r_tod_done;
        o_pop       = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop       = 1'b1;
                    n_quot      = i_q_data[TW-1:0];
                    n_flags     = t_job_flags'(i_q_data[TW+1:TW]);
                    n_cnt       = '0;
                    n_wd        = 3'd0;
                    n_hour      = 5'd0;
                    n_min       = 6'd0;
                    n_yoff      = '0;
                    n_m4        = 2'd2;
                    n_m100      = 7'd70;
                    n_m400      = 9'd370;
                    n_mon       = MONTH_JAN;
                    n_mon_phase = 1'b0;
                    n_cal_done  = 1'b0;
                    n_min_phase = 1'b0;
                    n_tod_done  = 1'b0;
                    n_state     = BK_DIV;
                end
            end
            BK_DIV: begin
                if (r_cnt == '0) begin
                    n_days = w_days_q;
                    n_cnt  = CW'(1);
                end else begin
                    n_sec   = w_sec_rem;
                    n_wd    = w_wd;
                    n_state = BK_WALK;
                end
            end
            BK_WALK: begin
                if (!r_mon_phase) begin
                    if (r_days >= DW'(w_year_len)) begin
                        n_days = r_days - DW'(w_year_len);
                        n_yoff = r_yoff + YW'(1);
                        n_m4   = r_m4 + 2'd1;
                        n_m100 = (r_m100 == 7'd99) ? 7'd0 : r_m100 + 7'd1;
                        n_m400 = (r_m400 == 9'd399) ? 9'd0 : r_m400 + 9'd1;
                    end else begin
                        n_doy       = r_days[8:0];
                        n_mon_phase = 1'b1;
                    end
                end else if (!r_cal_done) begin
                    if ((r_days < DW'(w_mon_len)) || (r_mon == MONTH_DEC)) begin
                        n_cal_done = 1'b1;
                    end else begin
                        n_days = r_days - DW'(w_mon_len);
                        n_mon  = r_mon + 4'd1;
                    end
                end
                if (!r_min_phase) begin
                    if (r_sec >= SEC_W'(SECS_PER_HOUR)) begin
                        n_sec  = r_sec - SEC_W'(SECS_PER_HOUR);
                        n_hour = r_hour + 5'd1;
                    end else begin
                        n_min_phase = 1'b1;
                    end
                end else if (!r_tod_done) begin
                    if (r_sec >= SEC_W'(SECS_PER_MIN)) begin
                        n_sec = r_sec - SEC_W'(SECS_PER_MIN);
                        n_min = r_min + 6'd1;
                    end else begin
                        n_tod_done = 1'b1;
                    end
                end
                if (r_cal_done && r_tod_done) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out.second_of_minute = r_sec[5:0];
                    n_out.minute_of_hour   = r_min;
                    n_out.hour_of_day      = r_hour;
                    n_out.weekday          = (w_wd4 >= 4'd7) ? 3'(w_wd4 - 4'd7) : w_wd4[2:0];
                    n_out.day_of_year      = r_doy;
                    n_out.month_index      = r_mon;
                    n_out.day_of_month     = 5'(r_days[4:0] + 5'd1);
                    n_out.years_since_1900 = w_year[7:0];
                    n_out.daylight_flag    = r_flags.daylight;
                    n_out.clamped          = r_flags.clamped;
                    n_out_valid            = 1'b1;
                    n_state                = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out       <= n_out;
        r_quot      <= n_quot;
        r_cnt       <= n_cnt;
        r_wd        <= n_wd;
        r_flags     <= n_flags;
        r_days      <= n_days;
        r_sec       <= n_sec;
        r_hour      <= n_hour;
        r_min       <= n_min;
        r_yoff      <= n_yoff;
        r_m4        <= n_m4;
        r_m100      <= n_m100;
        r_m400      <= n_m400;
        r_mon       <= n_mon;
        r_doy       <= n_doy;
        r_mon_phase <= n_mon_phase;
        r_cal_done  <= n_cal_done;
        r_min_phase <= n_min_phase;
        r_tod_done  <= n_tod_done;
    end

    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV && r_cnt == CW'(1)) |=> (r_state == BK_WALK))
        else $error("day split did not end after two steps");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DONE && (!r_out_valid || i_ready)) |=> (r_out_valid && r_state == BK_IDLE))
        else $error("finished item was not loaded into the result register");

endmodule

`default_nettype wire

>>> rtl/epoch_seconds_to_calendar_core.sv
// Top level of the epoch seconds to calendar converter.
// Depends on esc_pkg, esc_front, esc_queue and esc_back.
//
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_ready         i_epoch_seconds
// result    out        o_valid / i_ready         o_second_of_minute .. o_clamped
// config    in         i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
// The back stage takes a request, splits days from seconds by reciprocal multiplication,
// then walks years and months (one per cycle) while the hours and minutes walk alongside,
// and loads the result once the result register is free.
// Reset is synchronous and active low; it clears the configuration, state and valid registers and empties the queue.
// The input accepts items into a two-entry queue while the back stage is busy or its
// result waits to be taken.
`default_nettype none

module epoch_seconds_to_calendar_core #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [esc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [esc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [31:0]                     i_epoch_seconds,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [5:0]                           o_second_of_minute,
    output logic [5:0]                           o_minute_of_hour,
    output logic [4:0]                           o_hour_of_day,
    output logic [2:0]                           o_weekday,
    output logic [8:0]                           o_day_of_year,
    output logic [3:0]                           o_month_index,
    output logic [4:0]                           o_day_of_month,
    output logic [7:0]                           o_years_since_1900,
    output logic                                 o_daylight_flag,
    output logic                                 o_clamped
);
    import esc_pkg::*;

    localparam int QW = TIME_BITS + 3;

    logic          w_push;
    logic          w_push_ready;
    logic [QW-1:0] w_job;
    logic          w_q_valid;
    logic [QW-1:0] w_q_data;
    logic          w_pop;
    t_result       w_result;

    esc_front #(
        .TIME_BITS(TIME_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_epoch_seconds(i_epoch_seconds),
        .o_push         (w_push),
        .i_push_ready   (w_push_ready),
        .o_job          (w_job)
    );

    esc_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_job),
        .o_ready(w_push_ready),
        .o_valid(w_q_valid),
        .o_data (w_q_data),
        .i_pop  (w_pop)
    );

    esc_back #(
        .TIME_BITS(TIME_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(w_q_valid),
        .i_q_data (w_q_data),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (w_result)
    );

    assign o_second_of_minute = w_result.second_of_minute;
    assign o_minute_of_hour   = w_result.minute_of_hour;
    assign o_hour_of_day      = w_result.hour_of_day;
    assign o_weekday          = w_result.weekday;
    assign o_day_of_year      = w_result.day_of_year;
    assign o_month_index      = w_result.month_index;
    assign o_day_of_month     = w_result.day_of_month;
    assign o_years_since_1900 = w_result.years_since_1900;
    assign o_daylight_flag    = w_result.daylight_flag;
    assign o_clamped          = w_result.clamped;

endmodule

`default_nettype wire
